/* hdl/sqvs_pkg.sv */
// Shared types, constants and table functions for the sprite quad vertex setup block.
package sqvs_pkg;

	localparam int TRIG_TABLE_BITS_DEF = 10;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	localparam logic [16:0] UV_ONE = 17'd65536;

	typedef struct packed {
		logic signed [23:0] dest_x;
		logic signed [23:0] dest_y;
		logic [31:0] size_wh;
		logic signed [23:0] origin_x;
		logic signed [23:0] origin_y;
		logic [15:0] angle;
		logic [63:0] source_rect;
		logic [47:0] inv_tex_size;
		logic [31:0] tint;
		logic has_texture;
		logic [2:0] tex_slot;
		logic signed [15:0] z_index;
	} cmd_t;

	typedef struct packed {
		logic signed [23:0] vert_x;
		logic signed [23:0] vert_y;
		logic signed [15:0] vert_z;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [2:0] vert_slot;
		logic [1:0] corner;
		logic last;
	} vert_t;

	typedef struct packed {
		logic signed [25:0] lx0;
		logic signed [25:0] lx1;
		logic signed [25:0] ly0;
		logic signed [25:0] ly1;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
		logic signed [23:0] dx;
		logic signed [23:0] dy;
		logic [16:0] u0;
		logic [16:0] u1;
		logic [16:0] v0;
		logic [16:0] v1;
		logic signed [15:0] z;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic [2:0] slot;
	} setup_t;

	// Q1.15 sine table entry, evaluated at elaboration only
	function automatic logic signed [15:0] trig_entry(input int unsigned k,
		input int unsigned bits);
		longint unsigned q, kk, quad, r, m, t, x2, a, f;
		longint s;
		q = 64'd1 << (bits - 2);
		kk = longint'(k) & ((64'd1 << bits) - 64'd1);
		quad = kk >> (bits - 2);
		r = kk & (q - 64'd1);
		m = quad[0] ? (q - r) : r;
		t = (m * HALF_PI_Q30) >> (bits - 2);
		x2 = (t * t) >> 30;
		s = longint'(t);
		a = t;
		a = ((a * x2) >> 30) / 6;
		s = s - longint'(a);
		a = ((a * x2) >> 30) / 20;
		s = s + longint'(a);
		a = ((a * x2) >> 30) / 42;
		s = s - longint'(a);
		a = ((a * x2) >> 30) / 72;
		s = s + longint'(a);
		a = ((a * x2) >> 30) / 110;
		s = s - longint'(a);
		a = ((a * x2) >> 30) / 156;
		s = s + longint'(a);
		if (s < 0) begin
			s = 0;
		end
		f = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (f > 64'd32767) begin
			f = 64'd32767;
		end
		return quad[1] ? -16'(f) : 16'(f);
	endfunction

	// edge times Q0.24 inverse size, rounded to Q0.16, saturated at 1.0
	function automatic logic [16:0] uv_conv(input logic [16:0] e, input logic [23:0] inv);
		logic [40:0] p;
		logic [33:0] r;
		p = 41'(e) * 41'(inv);
		r = 34'((42'(p) + 42'd128) >> 8);
		return (r > 34'(UV_ONE)) ? UV_ONE : r[16:0];
	endfunction

	function automatic logic signed [23:0] sat_pos(input logic signed [28:0] v);
		if (v > 29'sd8388607) begin
			return 24'sh7fffff;
		end else if (v < -29'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

endpackage

/* hdl/sprite_quad_vertex_setup.sv */
// Top level of the sprite quad vertex setup block.
// channel | dir | handshake           | payload
// command | in  | push / full         | cmd  (sqvs_pkg::cmd_t)
// vertex  | out | pop / empty         | vert (sqvs_pkg::vert_t)
// One command yields four vertices, one per cycle while the output queue has room.
// The first vertex shows on vert after the table read register, mid queue, rotate multiply
// register and output queue.
// Back corner walk sets the rate: one shared rotate unit, one corner a cycle unless stalled.
// Reset clears only queue pointers, counters and valid flags; no clearing pass.
// A stalled result side fills the queues, then full rises.
module sprite_quad_vertex_setup #(
	parameter int TRIG_TABLE_BITS = sqvs_pkg::TRIG_TABLE_BITS_DEF,
	parameter int QUEUE_DEPTH = sqvs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sqvs_pkg::cmd_t cmd,
	output logic full,
	input  logic pop,
	output sqvs_pkg::vert_t vert,
	output logic empty
);
	logic mq_push, mq_full, mq_pop, mq_empty;
	sqvs_pkg::setup_t mq_wdata, mq_rdata;
	logic of_push, of_full;
	sqvs_pkg::vert_t of_data;

	sqvs_front #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .cmd(cmd), .full(full),
		.mq_push(mq_push), .mq_data(mq_wdata), .mq_full(mq_full)
	);

	sqvs_fifo #(.W($bits(sqvs_pkg::setup_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
		.clk(clk), .arst_n(arst_n),
		.push(mq_push), .wdata(mq_wdata), .full(mq_full),
		.pop(mq_pop), .rdata(mq_rdata), .empty(mq_empty)
	);

	sqvs_back u_back (
		.clk(clk), .arst_n(arst_n),
		.mq_data(mq_rdata), .mq_empty(mq_empty), .mq_pop(mq_pop),
		.of_push(of_push), .of_data(of_data), .of_full(of_full)
	);

	sqvs_fifo #(.W($bits(sqvs_pkg::vert_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.push(of_push), .wdata(of_data), .full(of_full),
		.pop(pop), .rdata(vert), .empty(empty)
	);
endmodule

/* hdl/sqvs_fifo.sv */
// Small register queue used between the front and back parts and at the result side.
module sqvs_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [W-1:0] wdata,
	output logic full,
	input  logic pop,
	output logic [W-1:0] rdata,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] regs_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = regs_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			regs_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

/* hdl/sqvs_front.sv */
// Front part: accepts a draw command, looks up sine and cosine, forms corner offsets and UVs.
module sqvs_front #(
	parameter int TRIG_TABLE_BITS = sqvs_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sqvs_pkg::cmd_t cmd,
	output logic full,
	output logic mq_push,
	output sqvs_pkg::setup_t mq_data,
	input  logic mq_full
);
	localparam int N = 1 << TRIG_TABLE_BITS;
	localparam int Q = 1 << (TRIG_TABLE_BITS - 2);

	logic signed [15:0] trig_rom [N];
	logic [TRIG_TABLE_BITS-1:0] sidx, cidx;
	logic take;
	logic v_s1;
	sqvs_pkg::cmd_t cmd_s1;
	logic signed [15:0] sn_s1, cs_s1;
	logic [23:0] w, h;
	logic [16:0] ex0, ex1, ey0, ey1;

	for (genvar k = 0; k < N; k++) begin : g_rom
		assign trig_rom[k] = sqvs_pkg::trig_entry(k, TRIG_TABLE_BITS);
	end

	assign sidx = cmd.angle[15 -: TRIG_TABLE_BITS];
	assign cidx = sidx + TRIG_TABLE_BITS'(Q);
	assign full = v_s1 && mq_full;
	assign take = push && !full;
	assign mq_push = v_s1 && !mq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (mq_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
			sn_s1 <= trig_rom[sidx];
			cs_s1 <= trig_rom[cidx];
		end
	end

	assign w = {cmd_s1.size_wh[31:16], 8'd0};
	assign h = {cmd_s1.size_wh[15:0], 8'd0};
	assign ex0 = {1'b0, cmd_s1.source_rect[63:48]};
	assign ey0 = {1'b0, cmd_s1.source_rect[47:32]};
	assign ex1 = ex0 + {1'b0, cmd_s1.source_rect[31:16]};
	assign ey1 = ey0 + {1'b0, cmd_s1.source_rect[15:0]};

	always_comb begin
		mq_data.lx0 = -{{2{cmd_s1.origin_x[23]}}, cmd_s1.origin_x};
		mq_data.ly0 = -{{2{cmd_s1.origin_y[23]}}, cmd_s1.origin_y};
		mq_data.lx1 = $signed({2'b00, w}) - {{2{cmd_s1.origin_x[23]}}, cmd_s1.origin_x};
		mq_data.ly1 = $signed({2'b00, h}) - {{2{cmd_s1.origin_y[23]}}, cmd_s1.origin_y};
		mq_data.sn = sn_s1;
		mq_data.cs = cs_s1;
		mq_data.dx = cmd_s1.dest_x;
		mq_data.dy = cmd_s1.dest_y;
		if (cmd_s1.has_texture) begin
			mq_data.u0 = sqvs_pkg::uv_conv(ex0, cmd_s1.inv_tex_size[47:24]);
			mq_data.v0 = sqvs_pkg::uv_conv(ey0, cmd_s1.inv_tex_size[23:0]);
			mq_data.u1 = sqvs_pkg::uv_conv(ex1, cmd_s1.inv_tex_size[47:24]);
			mq_data.v1 = sqvs_pkg::uv_conv(ey1, cmd_s1.inv_tex_size[23:0]);
		end else begin
			mq_data.u0 = '0;
			mq_data.v0 = '0;
			mq_data.u1 = sqvs_pkg::UV_ONE;
			mq_data.v1 = sqvs_pkg::UV_ONE;
		end
		mq_data.z = cmd_s1.z_index;
		mq_data.red = {cmd_s1.tint[31:24], cmd_s1.tint[31:24]};
		mq_data.green = {cmd_s1.tint[23:16], cmd_s1.tint[23:16]};
		mq_data.blue = {cmd_s1.tint[15:8], cmd_s1.tint[15:8]};
		mq_data.alpha = {cmd_s1.tint[7:0], cmd_s1.tint[7:0]};
		mq_data.slot = cmd_s1.tex_slot;
	end
endmodule

/* hdl/sqvs_back.sv */
// Back part: walks the four corners of a queued command, rotates, offsets and saturates.
module sqvs_back (
	input  logic clk,
	input  logic arst_n,
	input  sqvs_pkg::setup_t mq_data,
	input  logic mq_empty,
	output logic mq_pop,
	output logic of_push,
	output sqvs_pkg::vert_t of_data,
	input  logic of_full
);
	logic [1:0] cnt_q;
	logic issue, xi, yi;
	logic signed [25:0] lx, ly;
	logic v_s1;
	logic signed [41:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [23:0] dx_s1, dy_s1;
	sqvs_pkg::vert_t meta_s1;
	logic signed [42:0] px, py, rpx, rpy;
	logic signed [27:0] rx, ry;

	assign issue = !mq_empty && (!v_s1 || !of_full);
	assign mq_pop = issue && (cnt_q == sqvs_pkg::CORNER_BL);
	assign of_push = v_s1 && !of_full;
	assign xi = (cnt_q == sqvs_pkg::CORNER_TR) || (cnt_q == sqvs_pkg::CORNER_BR);
	assign yi = cnt_q[1];
	assign lx = xi ? mq_data.lx1 : mq_data.lx0;
	assign ly = yi ? mq_data.ly1 : mq_data.ly0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= sqvs_pkg::CORNER_TL;
			v_s1 <= 1'b0;
		end else begin
			if (issue) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (of_push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pa_s1 <= 42'(lx) * 42'(mq_data.cs);
			pb_s1 <= 42'(ly) * 42'(mq_data.sn);
			pc_s1 <= 42'(lx) * 42'(mq_data.sn);
			pd_s1 <= 42'(ly) * 42'(mq_data.cs);
			dx_s1 <= mq_data.dx;
			dy_s1 <= mq_data.dy;
			meta_s1.vert_x <= '0;
			meta_s1.vert_y <= '0;
			meta_s1.vert_z <= mq_data.z;
			meta_s1.red <= mq_data.red;
			meta_s1.green <= mq_data.green;
			meta_s1.blue <= mq_data.blue;
			meta_s1.alpha <= mq_data.alpha;
			meta_s1.tex_u <= xi ? mq_data.u1 : mq_data.u0;
			meta_s1.tex_v <= yi ? mq_data.v1 : mq_data.v0;
			meta_s1.vert_slot <= mq_data.slot;
			meta_s1.corner <= cnt_q;
			meta_s1.last <= cnt_q == sqvs_pkg::CORNER_BL;
		end
	end

	assign px = {pa_s1[41], pa_s1} - {pb_s1[41], pb_s1};
	assign py = {pc_s1[41], pc_s1} + {pd_s1[41], pd_s1};
	assign rpx = (px + 43'sd16384) >>> 15;
	assign rpy = (py + 43'sd16384) >>> 15;
	assign rx = rpx[27:0];
	assign ry = rpy[27:0];

	always_comb begin
		of_data = meta_s1;
		of_data.vert_x = sqvs_pkg::sat_pos({rx[27], rx} + {{5{dx_s1[23]}}, dx_s1});
		of_data.vert_y = sqvs_pkg::sat_pos({ry[27], ry} + {{5{dy_s1[23]}}, dy_s1});
	end

`ifndef SYNTH
	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("corner counter skipped");
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != sqvs_pkg::CORNER_TL |-> !mq_empty)
		else $error("command left queue mid quad");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && of_full |=> v_s1 && $stable(meta_s1) && $stable(pa_s1))
		else $error("stalled vertex changed");
`endif
endmodule
